FILE: hdl/cpu_alu_with_flags_defines.svh
// Assertion macros used by the checker file.
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CAWF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cpu_alu_with_flags: check failed");

// Antecedent implies consequent, evaluated from the same edge.
`define CAWF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("cpu_alu_with_flags: check failed");

`endif

FILE: hdl/cawf_pkg.sv
`timescale 1ns / 1ps

package cawf_pkg;

   localparam logic [4:0] OP_ADD        = 5'd0;
   localparam logic [4:0] OP_ADC        = 5'd1;
   localparam logic [4:0] OP_SUB        = 5'd2;
   localparam logic [4:0] OP_SBC        = 5'd3;
   localparam logic [4:0] OP_AND        = 5'd4;
   localparam logic [4:0] OP_XOR        = 5'd5;
   localparam logic [4:0] OP_OR         = 5'd6;
   localparam logic [4:0] OP_CP         = 5'd7;
   localparam logic [4:0] OP_INC8       = 5'd8;
   localparam logic [4:0] OP_DEC8       = 5'd9;
   localparam logic [4:0] OP_DAA        = 5'd10;
   localparam logic [4:0] OP_CPL        = 5'd11;
   localparam logic [4:0] OP_SCF        = 5'd12;
   localparam logic [4:0] OP_CCF        = 5'd13;
   localparam logic [4:0] OP_RLCA       = 5'd14;
   localparam logic [4:0] OP_RRCA       = 5'd15;
   localparam logic [4:0] OP_RLA        = 5'd16;
   localparam logic [4:0] OP_RRA        = 5'd17;
   localparam logic [4:0] OP_CB         = 5'd18;
   localparam logic [4:0] OP_ADD16      = 5'd19;
   localparam logic [4:0] OP_ADD_SP_REL = 5'd20;
   localparam logic [4:0] OP_INC16      = 5'd21;
   localparam logic [4:0] OP_DEC16      = 5'd22;

   // CB byte bits 7..6
   localparam logic [1:0] CB_GRP_SHIFT = 2'd0;
   localparam logic [1:0] CB_GRP_BIT   = 2'd1;
   localparam logic [1:0] CB_GRP_RES   = 2'd2;
   localparam logic [1:0] CB_GRP_SET   = 2'd3;

   // CB byte bits 5..3 within the shift group
   localparam logic [2:0] CB_RLC  = 3'd0;
   localparam logic [2:0] CB_RRC  = 3'd1;
   localparam logic [2:0] CB_RL   = 3'd2;
   localparam logic [2:0] CB_RR   = 3'd3;
   localparam logic [2:0] CB_SLA  = 3'd4;
   localparam logic [2:0] CB_SRA  = 3'd5;
   localparam logic [2:0] CB_SWAP = 3'd6;
   localparam logic [2:0] CB_SRL  = 3'd7;

   localparam logic [7:0] DAA_LIMIT_HI = 8'h99;
   localparam logic [3:0] DAA_LIMIT_LO = 4'h9;
   localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
   localparam logic [7:0] DAA_ADJ_HI   = 8'h60;

   typedef struct packed {
      logic [4:0]  op;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_result;
   } rsp_type;

endpackage

FILE: hdl/cpu_alu_with_flags.sv
`timescale 1ns / 1ps
// A start transfer reaches rsp_strobe through the input register and then the result register.
// Throughput: one operation per cycle; busy stays low, so start may be high every cycle.
// Each result is shown for one cycle only; the receiver cannot stall it.
// Reset (synchronous, active high) clears the pipeline valid flags; no result is pending after it.
module cpu_alu_with_flags (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cawf_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output cawf_pkg::rsp_type rsp_payload
);

   logic              req_valid_ff;
   logic              req_valid_in;
   cawf_pkg::req_type req_ff;
   cawf_pkg::req_type req_in;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   cawf_pkg::rsp_type rsp_payload_ff;
   cawf_pkg::rsp_type rsp_payload_in;

   logic [7:0]  a;
   logic [7:0]  b;
   logic [15:0] a16;
   logic [15:0] b16;
   logic [3:0]  f;
   logic        cin;
   logic        t_add;
   logic        t_sub;
   logic [8:0]  sum9;
   logic [4:0]  sum_lo;
   logic [8:0]  diff9;
   logic [4:0]  diff_lo;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic        daa_lo;
   logic        daa_hi;
   logic [7:0]  daa_adj;
   logic [7:0]  daa_res;
   logic [2:0]  cb_sel;
   logic [1:0]  cb_grp;
   logic [7:0]  cb_mask;
   logic [7:0]  shf_res;
   logic        shf_c;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] sp_res;
   logic [4:0]  sp_lo;
   logic [8:0]  sp_byte;
   logic [15:0] res;
   logic [3:0]  fo;
   logic        wr;

   assign busy = 1'b0;

   assign req_valid_in = start & ~busy;
   assign req_in       = start ? req_payload : req_ff;

   assign a   = req_ff.operand_a[7:0];
   assign b   = req_ff.operand_b[7:0];
   assign a16 = req_ff.operand_a;
   assign b16 = req_ff.operand_b;
   assign f   = req_ff.flags_in;
   assign cin = f[0];

   assign t_add   = (req_ff.op == cawf_pkg::OP_ADC) ? cin : 1'b0;
   assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, t_add};
   assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t_add};
   assign t_sub   = (req_ff.op == cawf_pkg::OP_SBC) ? cin : 1'b0;
   assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, t_sub};
   assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t_sub};
   assign inc8    = a + 8'd1;
   assign dec8    = a - 8'd1;

   assign daa_lo  = f[1] | (~f[2] & (a[3:0] > cawf_pkg::DAA_LIMIT_LO));
   assign daa_hi  = cin | (~f[2] & (a > cawf_pkg::DAA_LIMIT_HI));
   assign daa_adj = (daa_lo ? cawf_pkg::DAA_ADJ_LO : 8'd0)
                  | (daa_hi ? cawf_pkg::DAA_ADJ_HI : 8'd0);
   assign daa_res = f[2] ? (a - daa_adj) : (a + daa_adj);

   assign cb_sel  = b[5:3];
   assign cb_grp  = b[7:6];
   assign cb_mask = 8'd1 << cb_sel;

   assign sum17   = {1'b0, a16} + {1'b0, b16};
   assign sum13   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
   assign sp_res  = a16 + {{8{b[7]}}, b};
   assign sp_lo   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
   assign sp_byte = {1'b0, a16[7:0]} + {1'b0, b};

   always_comb begin
      case (cb_sel)
         cawf_pkg::CB_RLC: begin
            shf_res = {a[6:0], a[7]};
            shf_c   = a[7];
         end
         cawf_pkg::CB_RRC: begin
            shf_res = {a[0], a[7:1]};
            shf_c   = a[0];
         end
         cawf_pkg::CB_RL: begin
            shf_res = {a[6:0], cin};
            shf_c   = a[7];
         end
         cawf_pkg::CB_RR: begin
            shf_res = {cin, a[7:1]};
            shf_c   = a[0];
         end
         cawf_pkg::CB_SLA: begin
            shf_res = {a[6:0], 1'b0};
            shf_c   = a[7];
         end
         cawf_pkg::CB_SRA: begin
            shf_res = {a[7], a[7:1]};
            shf_c   = a[0];
         end
         cawf_pkg::CB_SWAP: begin
            shf_res = {a[3:0], a[7:4]};
            shf_c   = 1'b0;
         end
         default: begin
            shf_res = {1'b0, a[7:1]};
            shf_c   = a[0];
         end
      endcase
   end

   always_comb begin
      res = 16'd0;
      fo  = f;
      wr  = 1'b1;
      case (req_ff.op)
         cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
            res = {8'd0, sum9[7:0]};
            fo  = {sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]};
         end
         cawf_pkg::OP_SUB, cawf_pkg::OP_SBC: begin
            res = {8'd0, diff9[7:0]};
            fo  = {diff9[7:0] == 8'd0, 1'b1, diff_lo[4], diff9[8]};
         end
         cawf_pkg::OP_CP: begin
            wr = 1'b0;
            fo = {diff9[7:0] == 8'd0, 1'b1, diff_lo[4], diff9[8]};
         end
         cawf_pkg::OP_AND: begin
            res = {8'd0, a & b};
            fo  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         cawf_pkg::OP_XOR: begin
            res = {8'd0, a ^ b};
            fo  = {(a ^ b) == 8'd0, 3'b000};
         end
         cawf_pkg::OP_OR: begin
            res = {8'd0, a | b};
            fo  = {(a | b) == 8'd0, 3'b000};
         end
         cawf_pkg::OP_INC8: begin
            res = {8'd0, inc8};
            fo  = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
         end
         cawf_pkg::OP_DEC8: begin
            res = {8'd0, dec8};
            fo  = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, cin};
         end
         cawf_pkg::OP_DAA: begin
            res = {8'd0, daa_res};
            fo  = {daa_res == 8'd0, f[2], 1'b0, daa_hi};
         end
         cawf_pkg::OP_CPL: begin
            res = {8'd0, ~a};
            fo  = {f[3], 1'b1, 1'b1, cin};
         end
         cawf_pkg::OP_SCF: begin
            wr = 1'b0;
            fo = {f[3], 3'b001};
         end
         cawf_pkg::OP_CCF: begin
            wr = 1'b0;
            fo = {f[3], 2'b00, ~cin};
         end
         cawf_pkg::OP_RLCA: begin
            res = {8'd0, a[6:0], a[7]};
            fo  = {3'b000, a[7]};
         end
         cawf_pkg::OP_RRCA: begin
            res = {8'd0, a[0], a[7:1]};
            fo  = {3'b000, a[0]};
         end
         cawf_pkg::OP_RLA: begin
            res = {8'd0, a[6:0], cin};
            fo  = {3'b000, a[7]};
         end
         cawf_pkg::OP_RRA: begin
            res = {8'd0, cin, a[7:1]};
            fo  = {3'b000, a[0]};
         end
         cawf_pkg::OP_CB: begin
            case (cb_grp)
               cawf_pkg::CB_GRP_BIT: begin
                  wr = 1'b0;
                  fo = {(a & cb_mask) == 8'd0, 1'b0, 1'b1, cin};
               end
               cawf_pkg::CB_GRP_RES: begin
                  res = {8'd0, a & ~cb_mask};
               end
               cawf_pkg::CB_GRP_SET: begin
                  res = {8'd0, a | cb_mask};
               end
               default: begin
                  res = {8'd0, shf_res};
                  fo  = {shf_res == 8'd0, 2'b00, shf_c};
               end
            endcase
         end
         cawf_pkg::OP_ADD16: begin
            res = sum17[15:0];
            fo  = {f[3], 1'b0, sum13[12], sum17[16]};
         end
         cawf_pkg::OP_ADD_SP_REL: begin
            res = sp_res;
            fo  = {2'b00, sp_lo[4], sp_byte[8]};
         end
         cawf_pkg::OP_INC16: begin
            res = a16 + 16'd1;
         end
         cawf_pkg::OP_DEC16: begin
            res = a16 - 16'd1;
         end
         default: begin
            wr = 1'b0;
         end
      endcase
   end

   assign rsp_strobe_in               = req_valid_ff;
   assign rsp_payload_in.result       = res;
   assign rsp_payload_in.flags_out    = fo;
   assign rsp_payload_in.write_result = wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: hdl/cawf_checker.sv
`timescale 1ns / 1ps
`include "cpu_alu_with_flags_defines.svh"

module cawf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input cawf_pkg::req_type req_payload,
   input logic              rsp_strobe,
   input cawf_pkg::rsp_type rsp_payload
);

   `CAWF_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `CAWF_ASSERT_IMP(a_transfer_gives_rsp, clock, reset, start && !busy, ##2 rsp_strobe)
   `CAWF_ASSERT_IMP(a_rsp_has_transfer, clock, reset, rsp_strobe, $past(start && !busy, 2))
   `CAWF_ASSERT_IMP(a_no_write_zero, clock, reset, rsp_strobe && !rsp_payload.write_result, (rsp_payload.result == 16'd0))
   `CAWF_ASSERT_IMP(a_inc16_value, clock, reset, rsp_strobe && $past(start && req_payload.op == cawf_pkg::OP_INC16, 2), (rsp_payload.result == $past(req_payload.operand_a + 16'd1, 2)))

endmodule

bind cpu_alu_with_flags cawf_checker u_cawf_checker (.*);
